/* rtl/core/slmc_pkg.sv */
package slmc_pkg;

  // Frame and sample geometry.
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SIZE_W      = 11;
  localparam int COUNT_W     = 21;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int INC_W       = 3;

  // One queue entry: maxima found by one sample, and whether it closed the frame.
  typedef struct packed {
    logic [INC_W-1:0] inc;
    logic             last;
  } slmc_qent_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } slmc_qstat_t;

endpackage

/* rtl/core/strict_local_maxima_counter_top.sv */
// Channel   Direction  Word                         Handshake
// in_       input      in_sample_value (16, signed) in_valid / in_stall
// out_      output     out_peak_count (21)          out_valid / out_stall
// cfg_      input      cfg_index, cfg_wr_data (11)  cfg_wr_en, no wait
//
// Unless stalled, one sample is taken per clock and the front pipeline (line
// store read, window shift, neighbour compare) and the back tally each
// handle one word a cycle. Counts leave via the queue and the output
// register. Synchronous active-low reset clears control state only; the line
// stores are not swept, so the block is ready in the cycle after reset.
// Input stalls only when the four-entry queue could not hold every sample in
// flight, which happens only while the output register is held by out_stall.
module strict_local_maxima_counter_top import slmc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COUNT_W-1:0]            out_peak_count
);

  // The front keeps the frame position, the two line stores and the 3x3
  // window, and judges up to four candidate centres per sample. Each sample
  // leaves one queue word holding how many maxima it settled.
  logic        q_push;
  slmc_qent_t  q_push_ent;
  logic        q_pop;
  slmc_qent_t  q_head;
  slmc_qstat_t q_stat;

  slmc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_push_ent      (q_push_ent)
  );

  slmc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_push_ent),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // The back adds the queue words into the frame tally and hands the total
  // to the output register when the frame-closing word arrives. Both known
  // register indexes restart the frame, so every write clears the tally.
  slmc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .restart        (cfg_wr_en),
    .q_head         (q_head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_peak_count (out_peak_count)
  );

`ifndef ASSERT_OFF
  // The front's reservation must keep the queue from ever overflowing.
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_pop |-> (q_stat.count < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue written while full");

  // A result appears only after a frame-closing word has left the queue.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(q_pop && q_head.last))
    else $error("result without a completed frame");
`endif

endmodule

/* rtl/core/slmc_ram.sv */
module slmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* rtl/core/slmc_front.sv */
module slmc_front import slmc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  slmc_qstat_t                   q_stat,
  output logic                          q_push,
  output slmc_qent_t                    q_push_ent
);

  typedef struct packed {
    logic up_ok;
    logic top_ok;
    logic cl_ok;
    logic left_ok;
    logic last_col;
    logic last_row;
  } slmc_pos_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    if (v == '0) begin
      return SIZE_W'(1);
    end else if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

  logic [SIZE_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              s1_v_r, s2_v_r;
  logic              accept;
  logic [QCNT_W:0]   reserve;
  slmc_pos_t         pos;

  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic [COL_W-1:0]              s1_col_r;
  slmc_pos_t                     s1_pos_r, s2_pos_r;
  logic                          fwd_v_r;
  logic [SAMPLE_BITS-1:0]        fwd_upper_r, fwd_second_r;
  logic [SAMPLE_BITS-1:0]        upper_q, second_q, above2, above1;
  logic signed [SAMPLE_BITS-1:0] win_r [3][3];

  // Room is reserved for every sample still in the two front stages.
  assign reserve  = (QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(s1_v_r)
                  + (QCNT_W+1)'(s2_v_r);
  assign in_stall = reserve >= (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos.last_col = (SIZE_W'(col_r) + SIZE_W'(1)) >= width_r;
    pos.last_row = (SIZE_W'(row_r) + SIZE_W'(1)) >= height_r;
    pos.up_ok    = row_r != '0;
    pos.top_ok   = row_r > ROW_W'(1);
    pos.cl_ok    = col_r != '0;
    pos.left_ok  = col_r > COL_W'(1);
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          width_nxt = clamp_size(SIZE_W'(cfg_wr_data), SIZE_W'(MAX_WIDTH));
          col_nxt   = '0;
          row_nxt   = '0;
        end
        REG_FRAME_HEIGHT: begin
          height_nxt = clamp_size(SIZE_W'(cfg_wr_data), SIZE_W'(MAX_HEIGHT));
          col_nxt    = '0;
          row_nxt    = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (pos.last_col) begin
        col_nxt = '0;
        row_nxt = pos.last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(MAX_WIDTH);
      height_r <= SIZE_W'(MAX_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_v_r   <= accept;
      s2_v_r   <= s1_v_r;
    end
  end

  // A one-column frame reads the entry that the previous sample writes in
  // the same cycle, so that write is forwarded.
  assign above2 = fwd_v_r ? fwd_upper_r  : upper_q;
  assign above1 = fwd_v_r ? fwd_second_r : second_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r  <= in_sample_value;
      s1_col_r     <= col_r;
      s1_pos_r     <= pos;
      fwd_v_r      <= s1_v_r && (s1_col_r == col_r);
      fwd_upper_r  <= above1;
      fwd_second_r <= s1_sample_r;
    end
    if (s1_v_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= above2;
      win_r[1][2] <= above1;
      win_r[2][2] <= s1_sample_r;
      s2_pos_r    <= s1_pos_r;
    end
  end

  slmc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_upper_line (
    .clk     (clk),
    .wr_en   (s1_v_r),
    .wr_addr (s1_col_r),
    .wr_data (above1),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (upper_q)
  );

  slmc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_second_line (
    .clk     (clk),
    .wr_en   (s1_v_r),
    .wr_addr (s1_col_r),
    .wr_data (s1_sample_r),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (second_q)
  );

  // Window rows are rows r-2, r-1 and r; columns are c-2, c-1 and c.
  logic up, top, cl, left;
  logic en11, en12, en21, en22, j11, j12, j21, j22;

  always_comb begin
    up   = s2_pos_r.up_ok;
    top  = s2_pos_r.top_ok;
    cl   = s2_pos_r.cl_ok;
    left = s2_pos_r.left_ok;

    en11 = up && cl;
    j11  = (!(top && left) || (win_r[0][0] < win_r[1][1]))
        && (!top  || (win_r[0][1] < win_r[1][1]))
        && (!top  || (win_r[0][2] < win_r[1][1]))
        && (!left || (win_r[1][0] < win_r[1][1]))
        && (win_r[1][2] < win_r[1][1])
        && (!left || (win_r[2][0] < win_r[1][1]))
        && (win_r[2][1] < win_r[1][1])
        && (win_r[2][2] < win_r[1][1]);

    en12 = up && s2_pos_r.last_col;
    j12  = (!(top && cl) || (win_r[0][1] < win_r[1][2]))
        && (!top || (win_r[0][2] < win_r[1][2]))
        && (!cl  || (win_r[1][1] < win_r[1][2]))
        && (!cl  || (win_r[2][1] < win_r[1][2]))
        && (win_r[2][2] < win_r[1][2]);

    en21 = s2_pos_r.last_row && cl;
    j21  = (!(up && left) || (win_r[1][0] < win_r[2][1]))
        && (!up   || (win_r[1][1] < win_r[2][1]))
        && (!up   || (win_r[1][2] < win_r[2][1]))
        && (!left || (win_r[2][0] < win_r[2][1]))
        && (win_r[2][2] < win_r[2][1]);

    en22 = s2_pos_r.last_row && s2_pos_r.last_col;
    j22  = (!(up && cl) || (win_r[1][1] < win_r[2][2]))
        && (!up || (win_r[1][2] < win_r[2][2]))
        && (!cl || (win_r[2][1] < win_r[2][2]));

    q_push_ent.inc  = INC_W'(en11 && j11) + INC_W'(en12 && j12)
                    + INC_W'(en21 && j21) + INC_W'(en22 && j22);
    q_push_ent.last = en22;
  end

  assign q_push = s2_v_r;

endmodule

/* rtl/core/slmc_queue.sv */
module slmc_queue import slmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  slmc_qent_t  push_ent,
  input  logic        pop,
  output slmc_qent_t  head,
  output slmc_qstat_t stat
);

  slmc_qent_t        ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  assign head       = ent_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = count_r == '0;

endmodule

/* rtl/core/slmc_back.sv */
module slmc_back import slmc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  slmc_qent_t         q_head,
  input  slmc_qstat_t        q_stat,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] out_peak_count
);

  logic [COUNT_W-1:0] tally_r, tally_sum;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;

  assign tally_sum = tally_r + COUNT_W'(q_head.inc);
  // A frame-closing entry waits until the output register is free.
  assign q_pop = !q_stat.empty && (!q_head.last || !out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (restart) begin
        tally_r <= '0;
      end else if (q_pop) begin
        tally_r <= q_head.last ? '0 : tally_sum;
      end
      if (q_pop && q_head.last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      out_count_r <= tally_sum;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_peak_count = out_count_r;

endmodule

/* bench/tb_strict_local_maxima_counter_top.sv */
`timescale 1ns / 1ps

// Bench for the strict local maxima counter. Frames of signed samples are
// streamed in raster order. A model of the line stores and the 3x3 window,
// kept inside this module, works out the peak count that each completed
// frame should produce. Every count word that leaves the block is checked
// against the oldest count that is still outstanding.
module tb_strict_local_maxima_counter_top;
  import slmc_pkg::*;

  // A run stuck this long without any handshake is a hang.
  localparam int QUIET_LIMIT  = 2000;
  // Time allowed for the pipeline to empty before the frame size is rewritten.
  localparam int DRAIN_CYCLES = 8;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index       = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]         cfg_wr_data     = '0;
  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample_value = '0;
  logic                          out_valid;
  logic                          out_stall       = 1'b0;
  logic [COUNT_W-1:0]            out_peak_count;

  strict_local_maxima_counter_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_peak_count  (out_peak_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model of the block. The line stores hold the two rows above the current
  // one, and the window holds the last three columns of those three rows.
  logic signed [SAMPLE_BITS-1:0] two_rows_up [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] one_row_up  [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] win [3][3];
  int                            next_col;
  int                            next_row;
  int                            frame_w = MAX_WIDTH;
  int                            frame_h = MAX_HEIGHT;
  logic [COUNT_W-1:0]            peak_tally;
  logic [COUNT_W-1:0]            expected_peak_counts [$];
  logic [COUNT_W-1:0]            oldest_count;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int samples_sent       = 0;
  int frames_done        = 0;
  int errors             = 0;
  int quiet_cycles       = 0;

  // A size of zero means one, and anything past the maximum means the maximum.
  function automatic int clamp_dim(logic [CFG_DATA_W-1:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  function automatic void restart_frame();
    next_col   = 0;
    next_row   = 0;
    peak_tally = '0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win[r][c] = '0;
  endfunction

  // The window cell (wr, wc) holds the sample at frame position (fr, fc). It
  // is a peak when every neighbour that is both in the frame and in the
  // window is strictly smaller.
  function automatic bit is_peak(int wr, int wc, int fr, int fc);
    int nr;
    int nc;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr == 0 && dc == 0) continue;
        nr = fr + dr;
        nc = fc + dc;
        if (nr < 0 || nr >= frame_h || nc < 0 || nc >= frame_w) continue;
        if (wr + dr < 0 || wr + dr > 2 || wc + dc < 0 || wc + dc > 2) continue;
        if (win[wr + dr][wc + dc] >= win[wr][wc]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Shifts one accepted sample into the model. The centre of the window is
  // judged once its right-hand column has arrived, and on the last column or
  // the last row the samples that have nothing further to wait for are judged
  // at once. The last sample of the frame queues the count it should produce.
  function automatic void advance_peak_tally(logic signed [SAMPLE_BITS-1:0] s);
    int c;
    int r;
    bit last_col;
    bit last_row;
    c = next_col;
    r = next_row;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = two_rows_up[c];
    win[1][2] = one_row_up[c];
    win[2][2] = s;
    two_rows_up[c] = one_row_up[c];
    one_row_up[c]  = s;
    last_col = (c + 1 >= frame_w);
    last_row = (r + 1 >= frame_h);
    if (r >= 1 && c >= 1)     peak_tally += is_peak(1, 1, r - 1, c - 1);
    if (r >= 1 && last_col)   peak_tally += is_peak(1, 2, r - 1, c);
    if (last_row && c >= 1)   peak_tally += is_peak(2, 1, r, c - 1);
    if (last_row && last_col) peak_tally += is_peak(2, 2, r, c);
    if (!last_col) begin
      next_col = c + 1;
    end else begin
      next_col = 0;
      if (!last_row) begin
        next_row = r + 1;
      end else begin
        expected_peak_counts = {expected_peak_counts, peak_tally};
        frames_done++;
        restart_frame();
      end
    end
  endfunction

  // Half the samples come from a narrow band, so that ties and near ties are
  // common; the rest are full-range words or the two extremes.
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    int v;
    case ($urandom_range(3))
      0, 1: v = int'($urandom_range(6)) - 3;
      2: v = int'($urandom);
      default: v = $urandom_range(1) ? 32767 : -32768;
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Called at a falling edge. The sender may first sit idle for a random
  // number of cycles. The word is then held until the block takes it, and the
  // task returns at the next falling edge with valid still high, so that a
  // following call can keep it high without lowering it first.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid        <= 1'b1;
    in_sample_value <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_peak_tally(s);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    int n;
    n = frame_w * frame_h;
    for (int i = 0; i < n; i++) send_sample(random_sample());
  endtask

  // Lowers valid and holds off until every outstanding count has arrived and
  // the pipeline has had time to empty. It returns at a falling edge.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_peak_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes the width and then the height register on consecutive cycles. Each
  // write also throws away any frame that is part-way through.
  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_FRAME_WIDTH;
    cfg_wr_data <= w;
    @(posedge clk);
    frame_w = clamp_dim(w, MAX_WIDTH);
    restart_frame();
    @(negedge clk);
    cfg_index   <= REG_FRAME_HEIGHT;
    cfg_wr_data <= h;
    @(posedge clk);
    frame_h = clamp_dim(h, MAX_HEIGHT);
    restart_frame();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hand-picked frames: a single peak on a floor of the most negative value,
  // single-sample frames set up with zero sizes, a flat frame in which ties
  // give no peak, a frame cut short by a size write, one row and one column.
  task automatic test_directed();
    sender_idle_pct    = 25;
    receiver_stall_pct = 57;
    set_frame(11'd3, 11'd3);
    for (int i = 0; i < 9; i++) send_sample(i == 4 ? 16'sh7FFF : 16'sh8000);
    drain();
    set_frame(11'd0, 11'd0);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    drain();
    set_frame(11'd2, 11'd2);
    repeat (4) send_sample(16'sd5);
    drain();
    set_frame(11'd4, 11'd2);
    repeat (3) send_sample(16'sd7);
    drain();
    set_frame(11'd3, 11'd1);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd2);
    drain();
    set_frame(11'd1, 11'd3);
    send_sample(16'sd0);
    send_sample(16'sd5);
    send_sample(16'sd0);
    drain();
  endtask

  // One full-width row, set up with a width above the maximum and a height of
  // zero, so that both ends of the clamp are exercised as well.
  task automatic test_extreme_sizes();
    set_frame(11'd2047, 11'd0);
    send_frame();
    drain();
  endtask

  // Small frames of random size, one to four back to back per size. Now and
  // then a frame is left unfinished so that the next size write has to drop it.
  task automatic test_random_frames(input int idle_pct, input int stall_pct, input int items);
    int                    target;
    int                    cut;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    target = samples_sent + items;
    while (samples_sent < target) begin
      w = ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(12, 1));
      h = ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(8, 1));
      set_frame(w, h);
      repeat ($urandom_range(4, 1)) send_frame();
      if ($urandom_range(5) == 0 && frame_w * frame_h > 1) begin
        cut = $urandom_range(frame_w * frame_h - 1, 1);
        repeat (cut) send_sample(random_sample());
      end
      drain();
    end
  endtask

  // The receiver decides afresh on every cycle whether to hold the count word.
  always @(negedge clk) out_stall <= ($urandom_range(99) < receiver_stall_pct);

  // Every count word taken is compared with the oldest outstanding count.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_peak_counts.size() == 0) begin
        $display("%0t: peak count %0d arrived with no frame outstanding",
                 $time, out_peak_count);
        errors++;
      end else begin
        oldest_count = expected_peak_counts.pop_front();
        if (out_peak_count !== oldest_count) begin
          $display("%0t: peak count mismatch, expected %0d, got %0d",
                   $time, oldest_count, out_peak_count);
          errors++;
        end
      end
    end
  end

  // Any handshake or register write restarts the count of quiet cycles.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, giving up", $time, QUIET_LIMIT);
      $display("tb_strict_local_maxima_counter_top: done, errors");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      two_rows_up[i] = '0;
      one_row_up[i]  = '0;
    end
    restart_frame();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_extreme_sizes();
    test_random_frames(25, 57, 180);
    test_random_frames(57, 25, 180);
    test_random_frames(0, 0, 180);

    // Anything still outstanding after the final drain never arrived.
    if (expected_peak_counts.size() != 0) begin
      $display("%0t: %0d peak counts never arrived", $time, expected_peak_counts.size());
      errors += expected_peak_counts.size();
    end
    $display("Covered %0d samples and %0d whole frames, from 1x1 up to a full row,",
             samples_sent, frames_done);
    $display("with idling on either side and with none.");
    if (errors == 0) begin
      $display("tb_strict_local_maxima_counter_top: done, clean");
    end else begin
      $display("tb_strict_local_maxima_counter_top: done, errors");
    end
    $finish;
  end

endmodule
